// ----- hw/rtl/ptss_pkg.sv -----
`timescale 1ns / 1ps
// shared types, sizes and codes of the periodic task slot scheduler
package ptss_pkg;

  // table geometry
  localparam int NUM_SLOTS   = 16;
  localparam int PERIOD_BITS = 16;
  localparam int MAX_OUT     = 16;

  // derived internal widths
  localparam int SLOT_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TOTAL_W = $clog2(NUM_SLOTS + 1);
  localparam int EMIT_W  = $clog2(MAX_OUT + 1);

  // request queue between front and back, depth is a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // fixed port widths
  localparam int REQ_W      = 2;
  localparam int ID_W       = 8;
  localparam int PERIOD_W   = 16;
  localparam int STATUS_W   = 3;
  localparam int SLOT_IDX_W = 4;
  localparam int COUNT_W    = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_CONNECT    = 2'd0,
    REQ_DISCONNECT = 2'd1,
    REQ_TICK       = 2'd2,
    REQ_RUN        = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK         = 3'd0,
    STS_INVALID    = 3'd1,
    STS_ACTIVE     = 3'd2,
    STS_NOT_ACTIVE = 3'd3,
    STS_FULL       = 3'd4
  } status_e;

  typedef logic [ID_W-1:0]        task_id_t;
  typedef logic [PERIOD_BITS-1:0] period_t;

  // classified request handed from front to back
  typedef struct packed {
    req_e     req;
    logic     id_zero;
    task_id_t id;
    period_t  period;
  } cmd_t;

  // one result as driven on the output ports
  typedef struct packed {
    logic                  valid;
    status_e               status;
    logic                  task_valid;
    task_id_t              run_id;
    logic [SLOT_IDX_W-1:0] slot;
    logic [COUNT_W-1:0]    count;
    logic                  last;
  } result_t;

endpackage

// ----- hw/rtl/ptss_front.sv -----
`timescale 1ns / 1ps
// request front end: classifies requests and queues them for the back end
module ptss_front import ptss_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [ID_W-1:0]     task_id_i,
  input  logic [PERIOD_W-1:0] period_i,
  output logic                busy_o,
  output logic                cmd_valid_o,
  output cmd_t                cmd_o,
  input  logic                cmd_pop_i
);

  cmd_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;
  logic              push;
  cmd_t              cmd_new;

  // classify the incoming request
  always_comb begin
    cmd_new.req     = req_e'(req_type_i);
    cmd_new.id_zero = (task_id_i == '0);
    cmd_new.id      = task_id_i;
    cmd_new.period  = PERIOD_BITS'(period_i);
  end

  assign busy_o      = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign push        = start_i && !busy_o;
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = queue_q[rd_ptr_q];

  // queue pointers and fill level
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = cmd_pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    fill_d   = fill_q + QCNT_W'(push) - QCNT_W'(cmd_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// ----- hw/rtl/ptss_back.sv -----
`timescale 1ns / 1ps
// back end: slot table and the one-slot-per-cycle scan engine
module ptss_back import ptss_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  output result_t res_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  // slot table
  task_id_t task_q   [NUM_SLOTS];
  period_t  reload_q [NUM_SLOTS];
  period_t  count_q  [NUM_SLOTS];
  logic     ready_q  [NUM_SLOTS];
  logic [TOTAL_W-1:0] total_q, total_d;

  // scan control
  logic [1:0]        state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic              dup_q, dup_d;
  logic              free_ok_q, free_ok_d;
  logic [SLOT_W-1:0] free_idx_q, free_idx_d;
  logic              held_q, held_d;
  task_id_t          held_id_q, held_id_d;
  logic [SLOT_W-1:0] held_slot_q, held_slot_d;
  logic [EMIT_W-1:0] emit_n_q, emit_n_d;
  result_t           res_q, res_d;

  // table write controls
  logic              tbl_we;
  logic [SLOT_W-1:0] tbl_idx;
  task_id_t          tbl_task;
  period_t           tbl_period;
  logic              cnt_we;
  period_t           cnt_wd;
  logic              rdy_set, rdy_clr;

  // current slot view
  task_id_t          cur_task;
  period_t           cur_cnt, cur_rel;
  logic              cur_rdy, occupied, hit, last_slot;
  logic              dup_now, free_hit, free_ok_now;
  logic [SLOT_W-1:0] free_idx_now;

  function automatic result_t mk_res(status_e st, logic tv, task_id_t id,
                                     logic [SLOT_W-1:0] slot, logic lst);
    result_t r;
    r            = '0;
    r.valid      = 1'b1;
    r.status     = st;
    r.task_valid = tv;
    r.run_id     = id;
    r.slot       = SLOT_IDX_W'(slot);
    r.last       = lst;
    return r;
  endfunction

  assign cur_task  = task_q[idx_q];
  assign cur_cnt   = count_q[idx_q];
  assign cur_rel   = reload_q[idx_q];
  assign cur_rdy   = ready_q[idx_q];
  assign occupied  = (cur_task != '0);
  assign hit       = (cur_task == cmd_q.id);
  assign last_slot = (idx_q == SLOT_W'(NUM_SLOTS - 1));

  // lowest free slot and duplicate tracking for connect
  assign dup_now      = dup_q | hit;
  assign free_hit     = !occupied && !free_ok_q;
  assign free_ok_now  = free_ok_q | free_hit;
  assign free_idx_now = free_hit ? idx_q : free_idx_q;

  // scan sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    dup_d       = dup_q;
    free_ok_d   = free_ok_q;
    free_idx_d  = free_idx_q;
    held_d      = held_q;
    held_id_d   = held_id_q;
    held_slot_d = held_slot_q;
    emit_n_d    = emit_n_q;
    total_d     = total_q;
    res_d       = '0;
    cmd_pop_o   = 1'b0;
    tbl_we      = 1'b0;
    tbl_idx     = idx_q;
    tbl_task    = '0;
    tbl_period  = '0;
    cnt_we      = 1'b0;
    cnt_wd      = '0;
    rdy_set     = 1'b0;
    rdy_clr     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          idx_d     = '0;
          dup_d     = 1'b0;
          free_ok_d = 1'b0;
          held_d    = 1'b0;
          emit_n_d  = '0;
          state_d   = ST_SCAN;
          // bad id or full table answers at once
          if ((cmd_i.req == REQ_CONNECT &&
               (cmd_i.id_zero || total_q >= TOTAL_W'(NUM_SLOTS))) ||
              (cmd_i.req == REQ_DISCONNECT && cmd_i.id_zero)) begin
            res_d   = mk_res(STS_INVALID, 1'b0, '0, '0, 1'b1);
            state_d = ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        idx_d = idx_q + SLOT_W'(1);
        case (cmd_q.req)
          REQ_CONNECT: begin
            dup_d      = dup_now;
            free_ok_d  = free_ok_now;
            free_idx_d = free_idx_now;
            if (last_slot) begin
              state_d = ST_IDLE;
              if (dup_now) begin
                res_d = mk_res(STS_ACTIVE, 1'b0, '0, '0, 1'b1);
              end else if (free_ok_now) begin
                tbl_we     = 1'b1;
                tbl_idx    = free_idx_now;
                tbl_task   = cmd_q.id;
                tbl_period = cmd_q.period;
                total_d    = total_q + TOTAL_W'(1);
                res_d      = mk_res(STS_OK, 1'b0, '0, free_idx_now, 1'b1);
              end else begin
                res_d = mk_res(STS_FULL, 1'b0, '0, '0, 1'b1);
              end
            end
          end

          REQ_DISCONNECT: begin
            if (hit) begin
              tbl_we  = 1'b1;
              total_d = total_q - TOTAL_W'(total_q != '0);
              res_d   = mk_res(STS_OK, 1'b0, '0, idx_q, 1'b1);
              state_d = ST_IDLE;
            end else if (last_slot) begin
              res_d   = mk_res(STS_NOT_ACTIVE, 1'b0, '0, '0, 1'b1);
              state_d = ST_IDLE;
            end
          end

          REQ_TICK: begin
            if (occupied && cur_cnt != '0) begin
              cnt_we = 1'b1;
              if (cur_cnt == PERIOD_BITS'(1)) begin
                rdy_set = 1'b1;
                cnt_wd  = cur_rel;
              end else begin
                cnt_wd = cur_cnt - PERIOD_BITS'(1);
              end
            end
            if (last_slot) begin
              res_d   = mk_res(STS_OK, 1'b0, '0, '0, 1'b1);
              state_d = ST_IDLE;
            end
          end

          default: begin
            // run: emit the previously found task, hold the new one
            if (occupied && cur_rdy) begin
              rdy_clr = 1'b1;
              if (held_q) begin
                res_d = mk_res(STS_OK, 1'b1, held_id_q, held_slot_q, 1'b0);
              end
              held_d      = 1'b1;
              held_id_d   = cur_task;
              held_slot_d = idx_q;
              emit_n_d    = emit_n_q + EMIT_W'(1);
            end
            if (last_slot || emit_n_d == EMIT_W'(MAX_OUT)) begin
              state_d = ST_FIN;
            end
          end
        endcase
      end

      ST_FIN: begin
        // final result of a run carries the last mark
        if (held_q) begin
          res_d = mk_res(STS_OK, 1'b1, held_id_q, held_slot_q, 1'b1);
        end else begin
          res_d = mk_res(STS_OK, 1'b0, '0, '0, 1'b1);
        end
        state_d = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_d.count = COUNT_W'(total_d);
  end

  // control and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      total_q   <= '0;
      idx_q     <= '0;
      dup_q     <= 1'b0;
      free_ok_q <= 1'b0;
      held_q    <= 1'b0;
      emit_n_q  <= '0;
      res_q     <= '0;
    end else begin
      state_q   <= state_d;
      total_q   <= total_d;
      idx_q     <= idx_d;
      dup_q     <= dup_d;
      free_ok_q <= free_ok_d;
      held_q    <= held_d;
      emit_n_q  <= emit_n_d;
      res_q     <= res_d;
    end
  end

  // request payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    free_idx_q  <= free_idx_d;
    held_id_q   <= held_id_d;
    held_slot_q <= held_slot_d;
  end

  // slot table, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        task_q[i]   <= '0;
        reload_q[i] <= '0;
        count_q[i]  <= '0;
        ready_q[i]  <= 1'b0;
      end
    end else begin
      if (tbl_we) begin
        task_q[tbl_idx]   <= tbl_task;
        reload_q[tbl_idx] <= tbl_period;
        count_q[tbl_idx]  <= tbl_period;
      end else if (cnt_we) begin
        count_q[idx_q] <= cnt_wd;
      end
      if (rdy_set) begin
        ready_q[idx_q] <= 1'b1;
      end else if (rdy_clr) begin
        ready_q[idx_q] <= 1'b0;
      end
    end
  end

  assign res_o = res_q;

endmodule

// ----- hw/rtl/periodic_task_slot_scheduler.sv -----
`timescale 1ns / 1ps
// top level of the periodic task slot scheduler
//
// usage:
//   a request (connect, disconnect, tick, run) is taken at a rising edge with
//   start high and busy low; up to two requests wait in a queue, busy is high
//   while that queue is full
//   results appear on the result ports for one cycle each, flagged by
//   out_strobe_o; last_o marks the final result of a request
//   the receiver cannot hold results off, every strobe is a delivered result
// timing:
//   the back end walks the slot table one slot per cycle
//   connect, tick and unknown disconnect: the result follows the walk of the whole table
//   disconnect of a present id: the result comes once the walk reaches its slot
//   run: one result per ready task while walking
//   rejected id or full table: answered at once, with no walk
//   requests are carried out one after another; the queue still takes new
//   requests while the back end walks the table
// reset:
//   asynchronous, active low; clears the whole slot table, the count of
//   connected tasks and the queue, no clearing pass is needed
module periodic_task_slot_scheduler import ptss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [ID_W-1:0]       task_id_i,
  input  logic [PERIOD_W-1:0]   period_i,
  output logic                  out_strobe_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic                  task_valid_o,
  output logic [ID_W-1:0]       run_task_id_o,
  output logic [SLOT_IDX_W-1:0] slot_index_o,
  output logic [COUNT_W-1:0]    active_count_o,
  output logic                  last_o
);

  logic    cmd_valid;
  logic    cmd_pop;
  cmd_t    cmd;
  result_t res;

  // request classification and queue
  ptss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_type_i  (req_type_i),
    .task_id_i   (task_id_i),
    .period_i    (period_i),
    .busy_o      (busy),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // slot table and scan engine
  ptss_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res)
  );

  // result ports
  assign out_strobe_o   = res.valid;
  assign status_o       = res.status;
  assign task_valid_o   = res.task_valid;
  assign run_task_id_o  = res.run_id;
  assign slot_index_o   = res.slot;
  assign active_count_o = res.count;
  assign last_o         = res.last;

endmodule

// ----- hw/rtl/ptss_checker.sv -----
`timescale 1ns / 1ps
// port-level checks of the periodic task slot scheduler and their binding
module ptss_checker import ptss_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_strobe_o,
  input logic [STATUS_W-1:0]   status_o,
  input logic                  task_valid_o,
  input logic [ID_W-1:0]       run_task_id_o,
  input logic [SLOT_IDX_W-1:0] slot_index_o,
  input logic [COUNT_W-1:0]    active_count_o,
  input logic                  last_o
);

  // a task to run always comes from an ok run with a real id
  a_task_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && task_valid_o) |-> (status_o == STS_OK && run_task_id_o != '0))
    else $error("task result without ok status or with empty id");

  // every result that names no task closes its request
  a_plain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && !task_valid_o) |-> last_o)
    else $error("non-task result without last mark");

  // error results carry no slot and no id
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_strobe_o && status_o != STS_OK) |->
      (slot_index_o == '0 && run_task_id_o == '0 && !task_valid_o))
    else $error("error result carries slot or id");

  // status code and connected count stay in range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_strobe_o |-> (status_o <= STS_FULL &&
                      active_count_o <= COUNT_W'(NUM_SLOTS)))
    else $error("status or active count out of range");

endmodule

bind periodic_task_slot_scheduler ptss_checker u_ptss_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_strobe_o   (out_strobe_o),
  .status_o       (status_o),
  .task_valid_o   (task_valid_o),
  .run_task_id_o  (run_task_id_o),
  .slot_index_o   (slot_index_o),
  .active_count_o (active_count_o),
  .last_o         (last_o)
);

// ----- dv/periodic_task_slot_scheduler_tb.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the periodic task slot scheduler
module periodic_task_slot_scheduler_tb;
  import ptss_pkg::*;

  // one result as seen on the result ports
  typedef struct {
    status_e               status;
    logic                  task_valid;
    task_id_t              run_id;
    logic [SLOT_IDX_W-1:0] slot;
    logic [COUNT_W-1:0]    count;
    logic                  last;
  } sched_result_t;

  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN} traffic_mix_e;

  // slot table shadow and queue of results still owed by the block
  class slot_table_scoreboard;
    bit [ID_W-1:0]        slot_task [NUM_SLOTS];
    bit [PERIOD_BITS-1:0] slot_reload [NUM_SLOTS];
    bit [PERIOD_BITS-1:0] slot_count [NUM_SLOTS];
    bit                   slot_ready [NUM_SLOTS];
    int unsigned          active_total;
    sched_result_t        expected_results [$];
    int unsigned          errors;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_task[i]   = '0;
        slot_reload[i] = '0;
        slot_count[i]  = '0;
        slot_ready[i]  = 1'b0;
      end
      active_total = 0;
      errors = 0;
    endfunction

    // lowest slot holding this id, -1 when none (id 0 finds a free slot)
    function int find_slot(bit [ID_W-1:0] id);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_task[i] == id) return i;
      end
      return -1;
    endfunction

    // a connected id at random, or a random nonzero id when the table is empty
    function task_id_t pick_live_id();
      task_id_t live [$];
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_task[i] != 0) live.push_back(slot_task[i]);
      end
      if (live.size() == 0) return task_id_t'($urandom_range(1, 255));
      return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // update the shadow table for an accepted request and queue its results
    function void note_request(req_e req, task_id_t id, logic [PERIOD_W-1:0] per);
      sched_result_t r;
      period_t       p;
      int            hit;
      int            total;
      int            n;
      p = period_t'(per);
      r.status     = STS_OK;
      r.task_valid = 1'b0;
      r.run_id     = '0;
      r.slot       = '0;
      r.last       = 1'b1;
      case (req)
        REQ_CONNECT: begin
          if (id == 0 || active_total >= NUM_SLOTS) begin
            r.status = STS_INVALID;
          end else if (find_slot(id) >= 0) begin
            r.status = STS_ACTIVE;
          end else begin
            hit = find_slot('0);
            if (hit < 0) begin
              r.status = STS_FULL;
            end else begin
              // ready flag of a reused slot is left alone
              slot_task[hit]   = id;
              slot_reload[hit] = p;
              slot_count[hit]  = p;
              active_total++;
              r.slot = SLOT_IDX_W'(hit);
            end
          end
        end
        REQ_DISCONNECT: begin
          hit = (id == 0) ? -1 : find_slot(id);
          if (id == 0) begin
            r.status = STS_INVALID;
          end else if (hit < 0) begin
            r.status = STS_NOT_ACTIVE;
          end else begin
            slot_task[hit]   = '0;
            slot_reload[hit] = '0;
            slot_count[hit]  = '0;
            if (active_total > 0) active_total--;
            r.slot = SLOT_IDX_W'(hit);
          end
        end
        REQ_TICK: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_task[i] != 0 && slot_count[i] != 0) begin
              slot_count[i]--;
              if (slot_count[i] == 0) begin
                slot_ready[i] = 1'b1;
                slot_count[i] = slot_reload[i];
              end
            end
          end
        end
        default: begin
          // run: ready occupied slots in slot order, at most MAX_OUT of them
          total = 0;
          for (int i = 0; i < NUM_SLOTS; i++) begin
            if (slot_task[i] != 0 && slot_ready[i] && total < MAX_OUT) total++;
          end
          n = 0;
          for (int i = 0; i < NUM_SLOTS && n < total; i++) begin
            if (slot_task[i] != 0 && slot_ready[i]) begin
              slot_ready[i] = 1'b0;
              r.task_valid  = 1'b1;
              r.run_id      = slot_task[i];
              r.slot        = SLOT_IDX_W'(i);
              r.count       = COUNT_W'(active_total);
              r.last        = (n == total - 1);
              expected_results.push_back(r);
              n++;
            end
          end
          if (total > 0) return;
        end
      endcase
      r.count = COUNT_W'(active_total);
      expected_results.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    // compare one delivered result against the oldest one owed
    function void check_result(sched_result_t got);
      sched_result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual status %0d id %0d slot %0d",
                 $time, got.status, got.run_id, got.slot);
        return;
      end
      want = expected_results.pop_front();
      check_field("status", want.status, got.status);
      check_field("task_valid", want.task_valid, got.task_valid);
      check_field("run_task_id", want.run_id, got.run_id);
      check_field("slot_index", want.slot, got.slot);
      check_field("active_count", want.count, got.count);
      check_field("last", want.last, got.last);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [REQ_W-1:0]      req_type_i = '0;
  logic [ID_W-1:0]       task_id_i = '0;
  logic [PERIOD_W-1:0]   period_i = '0;
  logic                  out_strobe_o;
  logic [STATUS_W-1:0]   status_o;
  logic                  task_valid_o;
  logic [ID_W-1:0]       run_task_id_o;
  logic [SLOT_IDX_W-1:0] slot_index_o;
  logic [COUNT_W-1:0]    active_count_o;
  logic                  last_o;

  slot_table_scoreboard sb = new();
  traffic_mix_e         mix = MIX_FILL;

  periodic_task_slot_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .task_id_i      (task_id_i),
    .period_i       (period_i),
    .out_strobe_o   (out_strobe_o),
    .status_o       (status_o),
    .task_valid_o   (task_valid_o),
    .run_task_id_o  (run_task_id_o),
    .slot_index_o   (slot_index_o),
    .active_count_o (active_count_o),
    .last_o         (last_o)
  );

  // 2 ns clock
  always #1 clk_i = ~clk_i;

  // result monitor, every strobe is a delivered result
  always @(posedge clk_i) begin
    sched_result_t got;
    if (rst_ni && out_strobe_o) begin
      got.status     = status_e'(status_o);
      got.task_valid = task_valid_o;
      got.run_id     = run_task_id_o;
      got.slot       = slot_index_o;
      got.count      = active_count_o;
      got.last       = last_o;
      sb.check_result(got);
    end
  end

  // present one request and hold it until the block takes it
  task automatic send_request(input req_e req, input task_id_t id,
                              input logic [PERIOD_W-1:0] per);
    start      <= 1'b1;
    req_type_i <= req;
    task_id_i  <= id;
    period_i   <= per;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_request(req, id, per);
  endtask

  // drop start for a while, with junk on the request fields
  task automatic idle_gap(input int cycles);
    start      <= 1'b0;
    req_type_i <= REQ_W'($urandom);
    task_id_i  <= ID_W'($urandom);
    period_i   <= PERIOD_W'($urandom);
    repeat (cycles) @(posedge clk_i);
  endtask

  function automatic logic [PERIOD_W-1:0] random_period();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return PERIOD_W'($urandom_range(1, 3));
      4, 5:       return PERIOD_W'($urandom_range(4, 20));
      6:          return '0;
      7:          return '1;
      default:    return PERIOD_W'($urandom);
    endcase
  endfunction

  // random request shaped by the current traffic mix
  task automatic random_request(output req_e req, output task_id_t id,
                                output logic [PERIOD_W-1:0] per);
    int roll;
    roll = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:  req = (roll < 55) ? REQ_CONNECT : (roll < 75) ? REQ_TICK :
                       (roll < 90) ? REQ_RUN : REQ_DISCONNECT;
      MIX_DRAIN: req = (roll < 50) ? REQ_DISCONNECT : (roll < 70) ? REQ_TICK :
                       (roll < 90) ? REQ_RUN : REQ_CONNECT;
      default:   req = req_e'(roll % 4);
    endcase
    roll = $urandom_range(0, 99);
    if (req == REQ_CONNECT) begin
      id = (roll < 8) ? '0 : (roll < 30) ? sb.pick_live_id() : task_id_t'($urandom_range(1, 255));
    end else if (req == REQ_DISCONNECT) begin
      id = (roll < 8) ? '0 : (roll < 25) ? task_id_t'($urandom_range(1, 255)) : sb.pick_live_id();
    end else begin
      id = task_id_t'($urandom);
    end
    per = random_period();
  endtask

  // stimulus
  initial begin
    req_e                req;
    task_id_t            id;
    logic [PERIOD_W-1:0] per;
    int                  sent;
    int                  next_switch;
    int                  burst;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, rejected ids and unknown disconnect
    send_request(REQ_RUN, 8'd0, 16'd0);
    send_request(REQ_CONNECT, 8'd0, 16'd5);
    send_request(REQ_DISCONNECT, 8'd0, 16'd0);
    send_request(REQ_DISCONNECT, 8'd77, 16'd0);
    // connects, a duplicate and period extremes
    send_request(REQ_CONNECT, 8'd255, 16'd0);
    send_request(REQ_CONNECT, 8'd1, 16'd1);
    send_request(REQ_CONNECT, 8'd1, 16'd9);
    send_request(REQ_CONNECT, 8'd128, 16'hFFFF);
    send_request(REQ_CONNECT, 8'd2, 16'd2);
    // firing and reload
    send_request(REQ_TICK, 8'd0, 16'd0);
    send_request(REQ_TICK, 8'd0, 16'd0);
    send_request(REQ_RUN, 8'd0, 16'd0);
    // ready flag left behind by a disconnect carries over to the next tenant
    send_request(REQ_TICK, 8'd0, 16'd0);
    send_request(REQ_DISCONNECT, 8'd1, 16'd0);
    // fill the table, then one connect too many, then a tick and a run over the full table
    for (int k = 0; k < NUM_SLOTS - 3; k++) begin
      send_request(REQ_CONNECT, task_id_t'(8'h40 + k), 16'd1);
    end
    send_request(REQ_CONNECT, 8'hAA, 16'h5555);
    send_request(REQ_TICK, 8'd0, 16'd0);
    send_request(REQ_RUN, 8'd0, 16'd0);
    idle_gap(3);

    // random traffic in bursts, mix changes every few dozen requests
    sent = 0;
    next_switch = 0;
    while (sent < 390) begin
      burst = $urandom_range(1, 10);
      for (int b = 0; b < burst; b++) begin
        if (sent >= next_switch) begin
          mix = traffic_mix_e'($urandom_range(0, 2));
          next_switch = sent + $urandom_range(20, 60);
        end
        random_request(req, id, per);
        send_request(req, id, per);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 30));
    end
    // drop start unless an idle gap already did
    if (start) start <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (NUM_SLOTS + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/ptss_pkg.sv
hw/rtl/ptss_front.sv
hw/rtl/ptss_back.sv
hw/rtl/periodic_task_slot_scheduler.sv
hw/rtl/ptss_checker.sv
dv/periodic_task_slot_scheduler_tb.sv
